/* rtl/spim_pkg.sv */
// shared types and constants of the spi master with fifos
package spim_pkg;

    localparam int WORD_W         = 16;
    localparam int MAX_FRAME_BITS = 16;
    localparam int MIN_FRAME_BITS = 4;
    localparam int LEN_W          = 5;
    localparam int BIT_IDX_W      = $clog2(WORD_W);
    localparam int DIV_W          = 8;
    localparam int DEF_FIFO_DEPTH = 8;

    localparam int CFG_ADDR_W  = 2;
    localparam int CFG_DATA_W  = 8;
    localparam int IN_TDATA_W  = 24;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 24;

    localparam logic [DIV_W-1:0] DIV_RESET  = 8'd2;
    localparam logic [LEN_W-1:0] LEN_RESET  = 5'd8;

    typedef enum logic [1:0] {
        REQ_WRITE  = 2'd0,
        REQ_READ   = 2'd1,
        REQ_STATUS = 2'd2,
        REQ_TICK   = 2'd3
    } req_type_t;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_CLOCK_DIVIDER = 2'd0,
        CFG_FRAME_BITS    = 2'd1,
        CFG_SPI_MODE      = 2'd2,
        CFG_ENABLE        = 2'd3
    } cfg_index_t;

    // first member sits in the top bits, so read_word ends up lowest
    typedef struct packed {
        logic              mosi;
        logic              sclk;
        logic              overrun;
        logic              rx_full;
        logic              rx_not_empty;
        logic              tx_empty;
        logic              tx_not_full;
        logic              busy_res;
        logic [WORD_W-1:0] read_word;
    } spim_result_t;

    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] n);
        logic [LEN_W-1:0] r;
        r = n;
        if (n < LEN_W'(MIN_FRAME_BITS))
            r = LEN_W'(MIN_FRAME_BITS);
        else if (n > LEN_W'(MAX_FRAME_BITS))
            r = LEN_W'(MAX_FRAME_BITS);
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] len_mask(input logic [LEN_W-1:0] n);
        logic [WORD_W-1:0] m;
        for (int i = 0; i < WORD_W; i++)
            m[i] = (LEN_W'(i) < n);
        return m;
    endfunction

endpackage

/* rtl/spim_mem.sv */
// fifo storage: one write port, one registered read port with write bypass
module spim_mem #(
    parameter int FIFO_DEPTH = spim_pkg::DEF_FIFO_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  wr_en,
    input  logic [$clog2(FIFO_DEPTH)-1:0]         wr_addr,
    input  logic [spim_pkg::WORD_W-1:0]           wr_data,
    input  logic                                  rd_en,
    input  logic [$clog2(FIFO_DEPTH)-1:0]         rd_addr,
    output logic [spim_pkg::WORD_W-1:0]           rd_data
);
    import spim_pkg::*;

    logic [WORD_W-1:0] mem_reg [FIFO_DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        // a write to the entry being read shows up in the read data
        if (rd_en)
        begin
            if (wr_en && (wr_addr == rd_addr))
                rd_data_reg <= wr_data;
            else
                rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/spim_engine.sv */
// fifo pointers, config registers and the serial shift engine
module spim_engine #(
    parameter int FIFO_DEPTH = spim_pkg::DEF_FIFO_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [spim_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [spim_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  exec,
    input  spim_pkg::req_type_t                   req,
    input  logic [spim_pkg::WORD_W-1:0]           wword,
    input  logic                                  miso,
    input  logic [spim_pkg::WORD_W-1:0]           tx_rd_data,
    input  logic [spim_pkg::WORD_W-1:0]           rx_rd_data,
    output logic                                  tx_wr_en,
    output logic [$clog2(FIFO_DEPTH)-1:0]         tx_wr_addr,
    output logic [spim_pkg::WORD_W-1:0]           tx_wr_data,
    output logic [$clog2(FIFO_DEPTH)-1:0]         tx_rd_addr,
    output logic                                  rx_wr_en,
    output logic [$clog2(FIFO_DEPTH)-1:0]         rx_wr_addr,
    output logic [spim_pkg::WORD_W-1:0]           rx_wr_data,
    output logic [$clog2(FIFO_DEPTH)-1:0]         rx_rd_addr,
    output spim_pkg::spim_result_t                result
);
    import spim_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);
    localparam int CW = $clog2(FIFO_DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(FIFO_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(FIFO_DEPTH);

    function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
        return (p == LAST_PTR) ? '0 : AW'(p + AW'(1));
    endfunction

    logic [DIV_W-1:0]  divider_reg;
    logic [LEN_W-1:0]  frame_bits_reg;
    logic [1:0]        spi_mode_reg;
    logic              enable_reg;

    logic [AW-1:0]     tx_head_reg, tx_head_next, tx_tail_reg, tx_tail_next;
    logic [AW-1:0]     rx_head_reg, rx_head_next, rx_tail_reg, rx_tail_next;
    logic [CW-1:0]     tx_count_reg, tx_count_next, rx_count_reg, rx_count_next;
    logic [WORD_W-1:0] shift_reg, shift_next;
    logic [LEN_W-1:0]  bit_index_reg, bit_index_next;
    logic [DIV_W-1:0]  presc_reg, presc_next;
    logic              clock_level_reg, clock_level_next;
    logic              frame_active_reg, frame_active_next;
    logic              overrun_reg, overrun_next;
    logic [1:0]        cur_mode_reg, cur_mode_next;
    logic [LEN_W-1:0]  cur_len_reg, cur_len_next;
    logic              mosi_reg, mosi_next;
    logic [WORD_W-1:0] read_word;

    always_comb
    begin
        logic [LEN_W-1:0]     start_len;
        logic [WORD_W-1:0]    start_word;
        logic [LEN_W-1:0]     len_m1;
        logic [LEN_W-1:0]     bit_inc;
        logic [DIV_W-2:0]     half;
        logic [DIV_W:0]       presc_inc;
        logic                 lvl;
        logic                 leading;

        tx_head_next      = tx_head_reg;
        tx_tail_next      = tx_tail_reg;
        tx_count_next     = tx_count_reg;
        rx_head_next      = rx_head_reg;
        rx_tail_next      = rx_tail_reg;
        rx_count_next     = rx_count_reg;
        shift_next        = shift_reg;
        bit_index_next    = bit_index_reg;
        presc_next        = presc_reg;
        clock_level_next  = clock_level_reg;
        frame_active_next = frame_active_reg;
        overrun_next      = overrun_reg;
        cur_mode_next     = cur_mode_reg;
        cur_len_next      = cur_len_reg;
        mosi_next         = mosi_reg;
        read_word         = '0;
        tx_wr_en          = 1'b0;
        tx_wr_data        = wword;
        rx_wr_en          = 1'b0;
        rx_wr_data        = '0;

        start_len  = clamp_len(frame_bits_reg);
        start_word = tx_rd_data & len_mask(start_len);
        len_m1     = LEN_W'(cur_len_reg - LEN_W'(1));
        bit_inc    = LEN_W'(bit_index_reg + LEN_W'(1));
        half       = divider_reg[DIV_W-1:1];
        if (half == '0)
            half = (DIV_W-1)'(1);
        presc_inc  = {1'b0, presc_reg} + (DIV_W+1)'(1);
        lvl        = ~clock_level_reg;
        leading    = (lvl != cur_mode_reg[1]);

        if (exec)
        begin
            case (req)
                REQ_WRITE:
                begin
                    if (tx_count_reg < FULL_CNT)
                    begin
                        tx_wr_en      = 1'b1;
                        tx_tail_next  = ptr_inc(tx_tail_reg);
                        tx_count_next = CW'(tx_count_reg + CW'(1));
                    end
                end
                REQ_READ:
                begin
                    if (rx_count_reg != '0)
                    begin
                        read_word     = rx_rd_data;
                        rx_head_next  = ptr_inc(rx_head_reg);
                        rx_count_next = CW'(rx_count_reg - CW'(1));
                    end
                end
                REQ_TICK:
                begin
                    if (!frame_active_reg)
                    begin
                        clock_level_next = spi_mode_reg[1];
                        if (enable_reg && (tx_count_reg != '0))
                        begin
                            cur_len_next      = start_len;
                            cur_mode_next     = spi_mode_reg;
                            shift_next        = start_word;
                            tx_head_next      = ptr_inc(tx_head_reg);
                            tx_count_next     = CW'(tx_count_reg - CW'(1));
                            frame_active_next = 1'b1;
                            bit_index_next    = '0;
                            presc_next        = '0;
                            if (!spi_mode_reg[0])
                                mosi_next = start_word[BIT_IDX_W'(start_len - LEN_W'(1))];
                        end
                    end
                    else if (presc_inc < (DIV_W+1)'(half))
                    begin
                        presc_next = presc_inc[DIV_W-1:0];
                    end
                    else
                    begin
                        presc_next       = '0;
                        clock_level_next = lvl;
                        if (leading == !cur_mode_reg[0])
                            // sampling edge
                            shift_next = {shift_reg[WORD_W-2:0], miso}
                                         & len_mask(cur_len_reg);
                        else if (leading || (bit_inc < cur_len_reg))
                            // driving edge, none after the last bit in cpha 0
                            mosi_next = shift_reg[BIT_IDX_W'(len_m1)];
                        if (!leading)
                        begin
                            bit_index_next = bit_inc;
                            if (bit_inc >= cur_len_reg)
                            begin
                                if (rx_count_reg < FULL_CNT)
                                begin
                                    rx_wr_en      = 1'b1;
                                    rx_wr_data    = shift_next;
                                    rx_tail_next  = ptr_inc(rx_tail_reg);
                                    rx_count_next = CW'(rx_count_reg + CW'(1));
                                end
                                else
                                begin
                                    overrun_next = 1'b1;
                                end
                                frame_active_next = 1'b0;
                                bit_index_next    = '0;
                                presc_next        = '0;
                                clock_level_next  = spi_mode_reg[1];
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // idle clock level follows a mode write at once while no frame is active
        if (cfg_we && (cfg_index_t'(cfg_addr) == CFG_SPI_MODE) && !frame_active_reg)
            clock_level_next = cfg_wdata[1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            divider_reg      <= DIV_RESET;
            frame_bits_reg   <= LEN_RESET;
            spi_mode_reg     <= '0;
            enable_reg       <= 1'b0;
            tx_head_reg      <= '0;
            tx_tail_reg      <= '0;
            tx_count_reg     <= '0;
            rx_head_reg      <= '0;
            rx_tail_reg      <= '0;
            rx_count_reg     <= '0;
            shift_reg        <= '0;
            bit_index_reg    <= '0;
            presc_reg        <= '0;
            clock_level_reg  <= 1'b0;
            frame_active_reg <= 1'b0;
            overrun_reg      <= 1'b0;
            cur_mode_reg     <= '0;
            cur_len_reg      <= LEN_RESET;
            mosi_reg         <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index_t'(cfg_addr))
                    CFG_CLOCK_DIVIDER: divider_reg    <= cfg_wdata;
                    CFG_FRAME_BITS:    frame_bits_reg <= cfg_wdata[LEN_W-1:0];
                    CFG_SPI_MODE:      spi_mode_reg   <= cfg_wdata[1:0];
                    CFG_ENABLE:        enable_reg     <= cfg_wdata[0];
                    default:           enable_reg     <= enable_reg;
                endcase
            end
            tx_head_reg      <= tx_head_next;
            tx_tail_reg      <= tx_tail_next;
            tx_count_reg     <= tx_count_next;
            rx_head_reg      <= rx_head_next;
            rx_tail_reg      <= rx_tail_next;
            rx_count_reg     <= rx_count_next;
            shift_reg        <= shift_next;
            bit_index_reg    <= bit_index_next;
            presc_reg        <= presc_next;
            clock_level_reg  <= clock_level_next;
            frame_active_reg <= frame_active_next;
            overrun_reg      <= overrun_next;
            cur_mode_reg     <= cur_mode_next;
            cur_len_reg      <= cur_len_next;
            mosi_reg         <= mosi_next;
        end
    end

    // reads are issued at the head the next transaction will see
    assign tx_wr_addr = tx_tail_reg;
    assign tx_rd_addr = tx_head_next;
    assign rx_wr_addr = rx_tail_reg;
    assign rx_rd_addr = rx_head_next;

    assign result.read_word    = read_word;
    assign result.busy_res     = frame_active_next || (tx_count_next != '0);
    assign result.tx_not_full  = (tx_count_next < FULL_CNT);
    assign result.tx_empty     = (tx_count_next == '0);
    assign result.rx_not_empty = (rx_count_next != '0);
    assign result.rx_full      = (rx_count_next >= FULL_CNT);
    assign result.overrun      = overrun_next;
    assign result.sclk         = clock_level_next;
    assign result.mosi         = mosi_next;

endmodule

/* rtl/spi_master_with_fifos.sv */
// Top level of the spi master with fifos. Every input transaction (write, data read,
// status read or clock tick) gives exactly one result transaction; it is held in the
// s1 registers, then in the output register once the output is free. One transaction
// is taken every clock cycle while the output is not stalled: the transmit and receive
// words sit in two fifo memories with a registered read, which is issued as a
// transaction is accepted so that the word is at hand when it executes; a write to
// the entry being read is bypassed. Each tick advances the prescaler by one; an spi
// half period lasts clock_divider/2 ticks (at least one). Configuration writes are
// taken at any cycle and should be made while no transaction is in flight.
module spi_master_with_fifos #(
    parameter int FIFO_DEPTH = spim_pkg::DEF_FIFO_DEPTH
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [spim_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [spim_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // write_word [15:0], miso_bit [16], zero fill [23:17]
    input  logic [spim_pkg::IN_TDATA_W-1:0]       s_tdata,
    // req_type [1:0]
    input  logic [spim_pkg::IN_TUSER_W-1:0]       s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // read_word [15:0], busy_res, tx_not_full, tx_empty, rx_not_empty, rx_full,
    // overrun, sclk, mosi [23]
    output logic [spim_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import spim_pkg::*;

    localparam int AW = $clog2(FIFO_DEPTH);

    logic              s1_valid_reg;
    req_type_t         s1_req_reg;
    logic [WORD_W-1:0] s1_wword_reg;
    logic              s1_miso_reg;
    logic              out_valid_reg;
    spim_result_t      out_data_reg;

    logic              exec;
    logic              accept;
    spim_result_t      result;

    logic              tx_wr_en, rx_wr_en;
    logic [AW-1:0]     tx_wr_addr, tx_rd_addr, rx_wr_addr, rx_rd_addr;
    logic [WORD_W-1:0] tx_wr_data, rx_wr_data, tx_rd_data, rx_rd_data;

    assign exec     = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || exec;
    assign accept   = s_tvalid && s_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (exec)
                s1_valid_reg <= 1'b0;
            if (exec)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_req_reg   <= req_type_t'(s_tuser);
            s1_wword_reg <= s_tdata[WORD_W-1:0];
            s1_miso_reg  <= s_tdata[WORD_W];
        end
        if (exec)
        begin
            out_data_reg <= result;
        end
    end

    spim_engine #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_addr   (cfg_addr),
        .cfg_wdata  (cfg_wdata),
        .exec       (exec),
        .req        (s1_req_reg),
        .wword      (s1_wword_reg),
        .miso       (s1_miso_reg),
        .tx_rd_data (tx_rd_data),
        .rx_rd_data (rx_rd_data),
        .tx_wr_en   (tx_wr_en),
        .tx_wr_addr (tx_wr_addr),
        .tx_wr_data (tx_wr_data),
        .tx_rd_addr (tx_rd_addr),
        .rx_wr_en   (rx_wr_en),
        .rx_wr_addr (rx_wr_addr),
        .rx_wr_data (rx_wr_data),
        .rx_rd_addr (rx_rd_addr),
        .result     (result)
    );

    spim_mem #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_tx_mem (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_wr_addr),
        .wr_data (tx_wr_data),
        .rd_en   (accept),
        .rd_addr (tx_rd_addr),
        .rd_data (tx_rd_data)
    );

    spim_mem #(
        .FIFO_DEPTH (FIFO_DEPTH)
    ) u_rx_mem (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_wr_addr),
        .wr_data (rx_wr_data),
        .rd_en   (accept),
        .rd_addr (rx_rd_addr),
        .rd_data (rx_rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = OUT_TDATA_W'(out_data_reg);

    // an executed transaction always lands in the output register
    a_exec_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        exec |=> out_valid_reg)
        else $error("executed transaction did not reach the output");

    // words waiting in the transmit fifo mean busy
    a_busy_tx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.tx_empty || out_data_reg.busy_res))
        else $error("busy low with transmit words pending");

    // a full receive fifo is never reported empty
    a_rx_flags: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (!out_data_reg.rx_full || out_data_reg.rx_not_empty))
        else $error("receive fifo flags disagree");

    // input stalls only while a result is held and not taken
    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> (out_valid_reg && !m_tready))
        else $error("input stalled with a free output");

endmodule
